// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock outside reset
`define RSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition in one cycle implies another in the next
`define RSI_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/rsi_pkg.sv =====
// shared types, constants and helpers for the ray/sphere intersection block
// no dependencies
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    localparam logic signed [31:0] CENTER_Z_RST = 32'(10 << FRAC_BITS);
    localparam logic [30:0]        RADIUS_RST   = 31'(1 << FRAC_BITS);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 8'd3;

    // square root of disc << FRAC_BITS, disc is at most 31 bits
    localparam int SQ_IN_W  = 31 + FRAC_BITS;
    localparam int SQ_W     = (SQ_IN_W + 1) / 2;
    localparam int SQ_REM_W = SQ_W + 3;

    // divide |num| << FRAC_BITS by 2a
    localparam int NUM_W = 34;
    localparam int DEN_W = 33;
    localparam int QT_W  = 33;
    localparam int MAG_W = DEN_W + FRAC_BITS;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] distance;
        logic               saturated;
    } t_result;

    // one ray after the front end: direction and origin relative to center
    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] oc_x;
        logic signed [31:0] oc_y;
        logic signed [31:0] oc_z;
    } t_work;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < 64'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hw/rtl/rsi_front.sv =====
// front end: configuration registers, ray intake and origin-to-center offset
// depends on rsi_pkg
`timescale 1ns / 1ps

module rsi_front
    import rsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_ray                 i_in_ray,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_work                o_work,
    output logic [30:0]          o_radius
);

    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic signed [31:0] r_center_z;
    logic [30:0]        r_radius;
    logic               r_fv;
    t_work              r_work;
    t_work              n_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= CENTER_Z_RST;
            r_radius   <= RADIUS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_CENTER_Z: r_center_z <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_fv || !i_q_full;
    assign o_push     = r_fv && !i_q_full;

    always_comb begin
        n_work.dir_x = i_in_ray.dir_x;
        n_work.dir_y = i_in_ray.dir_y;
        n_work.dir_z = i_in_ray.dir_z;
        n_work.oc_x  = sat32(64'(i_in_ray.origin_x) - 64'(r_center_x));
        n_work.oc_y  = sat32(64'(i_in_ray.origin_y) - 64'(r_center_y));
        n_work.oc_z  = sat32(64'(i_in_ray.origin_z) - 64'(r_center_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_in_ready) begin
            r_fv <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_work <= n_work;
        end
    end

    assign o_work   = r_work;
    assign o_radius = r_radius;

endmodule

// ===== hw/rtl/rsi_queue.sv =====
// short queue between front end and arithmetic pipeline
// depends on rsi_pkg and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rsi_queue
    import rsi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_push_data,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_data,
    input  logic  i_pop
);

    t_work              r_mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    `RSI_ASSERT(a_q_no_underflow, i_pop |-> r_cnt != '0, "pop from empty queue")
    `RSI_ASSERT(a_q_no_overflow, i_push |-> (r_cnt != Q_CNT_W'(Q_DEPTH)) || i_pop,
        "push into full queue")

endmodule

// ===== hw/rtl/rsi_back.sv =====
// arithmetic pipeline: dot products, discriminant, bit-serial square root
// and bit-serial divide, one stage per bit; depends on rsi_pkg, assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rsi_back
    import rsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_work       i_q_data,
    output logic        o_pop,
    input  logic [30:0] i_radius,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_res
);

    // products, sums, a*c/b*b, sqrt load and steps, divide load and steps, output
    localparam int NSTG = 3 + (SQ_W + 1) + (QT_W + 1) + 1;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_W-1:0]     root;
        logic [2*SQ_W-1:0]   rad;
        logic [31:0]         a;
        logic signed [31:0]  b;
        logic                hit;
    } t_sq;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QT_W-1:0]  q;
        logic [QT_W-1:0]  mlo;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
        logic             hit;
    } t_dv;

    logic              en;
    logic [NSTG-1:0]   r_vld;

    logic signed [63:0] r_dd [0:2];
    logic signed [63:0] r_do [0:2];
    logic signed [63:0] r_oo [0:2];
    logic [61:0]        r_rr;

    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [31:0] r_c;

    logic signed [63:0] r_bb;
    logic signed [63:0] r_ac;
    logic signed [31:0] r_a2;
    logic signed [31:0] r_b2;

    t_sq     r_sq [0:SQ_W];
    t_dv     r_dv [0:QT_W];
    t_result r_out;

    assign en    = !r_vld[NSTG-1] || i_out_ready;
    assign o_pop = en && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], o_pop};
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0] <= i_q_data.dir_x * i_q_data.dir_x;
            r_dd[1] <= i_q_data.dir_y * i_q_data.dir_y;
            r_dd[2] <= i_q_data.dir_z * i_q_data.dir_z;
            r_do[0] <= i_q_data.dir_x * i_q_data.oc_x;
            r_do[1] <= i_q_data.dir_y * i_q_data.oc_y;
            r_do[2] <= i_q_data.dir_z * i_q_data.oc_z;
            r_oo[0] <= i_q_data.oc_x * i_q_data.oc_x;
            r_oo[1] <= i_q_data.oc_y * i_q_data.oc_y;
            r_oo[2] <= i_q_data.oc_z * i_q_data.oc_z;
            r_rr    <= 62'(i_radius) * 62'(i_radius);
        end
    end

    // quadratic coefficients
    logic signed [63:0] n_sdd;
    logic signed [63:0] n_sdo;
    logic signed [63:0] n_soo;

    always_comb begin
        n_sdd = (r_dd[0] >>> FRAC_BITS) + (r_dd[1] >>> FRAC_BITS) + (r_dd[2] >>> FRAC_BITS);
        n_sdo = (r_do[0] >>> FRAC_BITS) + (r_do[1] >>> FRAC_BITS) + (r_do[2] >>> FRAC_BITS);
        n_soo = (r_oo[0] >>> FRAC_BITS) + (r_oo[1] >>> FRAC_BITS) + (r_oo[2] >>> FRAC_BITS)
              - $signed(64'(r_rr) >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= sat32(n_sdd);
            r_b <= sat32(n_sdo <<< 1);
            r_c <= sat32(n_soo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bb <= r_b * r_b;
            r_ac <= r_a * r_c;
            r_a2 <= r_a;
            r_b2 <= r_b;
        end
    end

    // discriminant and miss test, loads the square root
    logic signed [31:0] n_disc;

    always_comb begin
        n_disc = sat32((r_bb >>> FRAC_BITS) - ((r_ac >>> FRAC_BITS) <<< 2));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0].rem  <= '0;
            r_sq[0].root <= '0;
            r_sq[0].rad  <= (2*SQ_W)'({n_disc[30:0], {FRAC_BITS{1'b0}}});
            r_sq[0].a    <= r_a2;
            r_sq[0].b    <= r_b2;
            r_sq[0].hit  <= !n_disc[31] && (r_a2 != '0);
        end
    end

    // square root, one result bit per stage
    for (genvar k = 1; k <= SQ_W; k++) begin : g_sq
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic                ge;

        always_comb begin
            rem_sh = {r_sq[k-1].rem[SQ_REM_W-3:0], r_sq[k-1].rad[2*SQ_W-1 -: 2]};
            trial  = {1'b0, r_sq[k-1].root, 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k].rem  <= ge ? rem_sh - trial : rem_sh;
                r_sq[k].root <= {r_sq[k-1].root[SQ_W-2:0], ge};
                r_sq[k].rad  <= {r_sq[k-1].rad[2*SQ_W-3:0], 2'b00};
                r_sq[k].a    <= r_sq[k-1].a;
                r_sq[k].b    <= r_sq[k-1].b;
                r_sq[k].hit  <= r_sq[k-1].hit;
            end
        end
    end

    // numerator -b - s, loads the divider
    logic signed [NUM_W-1:0] n_num;
    logic signed [NUM_W-1:0] n_abs;
    logic [MAG_W-1:0]        n_mag;
    logic [DEN_W-1:0]        n_den;
    logic [DEN_W-1:0]        n_hi;

    always_comb begin
        n_num = -NUM_W'(r_sq[SQ_W].b) - $signed(NUM_W'(r_sq[SQ_W].root));
        n_abs = n_num[NUM_W-1] ? -n_num : n_num;
        n_mag = {n_abs[DEN_W-1:0], {FRAC_BITS{1'b0}}};
        n_den = {r_sq[SQ_W].a, 1'b0};
        n_hi  = DEN_W'(n_mag[MAG_W-1:QT_W]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0].rem <= n_hi;
            r_dv[0].q   <= '0;
            r_dv[0].mlo <= n_mag[QT_W-1:0];
            r_dv[0].den <= n_den;
            r_dv[0].neg <= n_num[NUM_W-1];
            r_dv[0].ovf <= n_hi >= n_den;
            r_dv[0].hit <= r_sq[SQ_W].hit;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 1; k <= QT_W; k++) begin : g_dv
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb begin
            trial = {r_dv[k-1].rem, r_dv[k-1].mlo[QT_W-1]};
            diff  = trial - {1'b0, r_dv[k-1].den};
            ge    = trial >= {1'b0, r_dv[k-1].den};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k].rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_dv[k].q   <= {r_dv[k-1].q[QT_W-2:0], ge};
                r_dv[k].mlo <= {r_dv[k-1].mlo[QT_W-2:0], 1'b0};
                r_dv[k].den <= r_dv[k-1].den;
                r_dv[k].neg <= r_dv[k-1].neg;
                r_dv[k].ovf <= r_dv[k-1].ovf;
                r_dv[k].hit <= r_dv[k-1].hit;
            end
        end
    end

    // sign, clamp and output register
    t_result          n_out;
    logic [QT_W-1:0]  n_q;
    logic [QT_W-1:0]  n_qneg;

    always_comb begin
        n_q    = r_dv[QT_W].q;
        n_qneg = -n_q;
        n_out  = '0;
        if (r_dv[QT_W].hit) begin
            n_out.hit = 1'b1;
            if (!r_dv[QT_W].neg) begin
                if (r_dv[QT_W].ovf || n_q[QT_W-1] || n_q[31]) begin
                    n_out.distance  = Q_MAX;
                    n_out.saturated = 1'b1;
                end else begin
                    n_out.distance = n_q[31:0];
                end
            end else begin
                if (r_dv[QT_W].ovf || (n_q > QT_W'(33'h0_8000_0000))) begin
                    n_out.distance  = Q_MIN;
                    n_out.saturated = 1'b1;
                end else begin
                    n_out.distance = n_qneg[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_res   = r_out;

    `RSI_ASSERT(a_miss_is_zero,
        r_vld[NSTG-1] && !r_out.hit |-> r_out.distance == '0 && !r_out.saturated,
        "miss result carries data")
    `RSI_ASSERT_NEXT(a_pop_enters, o_pop, r_vld[0], "popped transaction lost")

endmodule

// ===== hw/rtl/ray_sphere_intersect_top.sv =====
// top level of the ray/sphere intersection block
// depends on rsi_pkg, rsi_front, rsi_queue, rsi_back
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid/o_in_ready/i_in_ray) takes one ray per transaction:
// origin and direction, signed Q16.16. Output channel (o_out_valid/i_out_ready/
// o_out_res) returns one result per ray in order: hit flag, smaller root t and a
// flag set when t was clamped to the 32-bit range.
// Configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data) writes
// center x, y, z (indexes 0 to 2) and radius (index 3); other indexes are dropped.
// o_cfg_ready is always high. Write only while no ray is in flight.
// Throughput: one ray per cycle while the receiver takes results; the pipeline depth
// is set by the one-bit-per-stage square root and divide pipelines.
// Reset loads center (0, 0, 10.0), radius 1.0 and empties all stages.
// When the receiver stalls the whole arithmetic pipeline holds; the front end
// keeps taking rays into a four-entry queue and then drops o_in_ready.

module ray_sphere_intersect_top
    import rsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_ray                 i_in_ray,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_result              o_out_res
);

    logic        q_full;
    logic        q_push;
    t_work       q_in;
    logic        q_valid;
    t_work       q_out;
    logic        q_pop;
    logic [30:0] radius;

    assign o_cfg_ready = 1'b1;

    rsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_ray    (i_in_ray),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_work      (q_in),
        .o_radius    (radius)
    );

    rsi_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_out),
        .i_pop       (q_pop)
    );

    rsi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_pop       (q_pop),
        .i_radius    (radius),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

endmodule

// ===== bench/ray_sphere_intersect_top_tb.sv =====
// self-checking testbench for ray_sphere_intersect_top
// depends on rsi_pkg and the block rtl; predicts each ray result in fixed point
`timescale 1ns / 1ps

module ray_sphere_intersect_top_tb;
    import rsi_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_ray                 i_in_ray;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_result              o_out_res;

    ray_sphere_intersect_top u_top (.*);

    logic signed [63:0] sph_cx, sph_cy, sph_cz, sph_r;
    t_result            hit_queue[$];
    int                 err_cnt;
    bit                 idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // product scaled down, rounded toward minus infinity
    function automatic logic signed [63:0] qmul(input logic signed [63:0] u,
                                                input logic signed [63:0] v);
        logic signed [63:0] p;
        p = u * v;
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_result predict_hit(input t_ray r);
        logic signed [63:0] dx, dy, dz, ox, oy, oz, a, b, c, disc, num;
        logic [63:0]        s, mag, den, q;
        t_result            res;
        dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
        ox = clamp32(64'(r.origin_x) - sph_cx);
        oy = clamp32(64'(r.origin_y) - sph_cy);
        oz = clamp32(64'(r.origin_z) - sph_cz);
        a = clamp32(qmul(dx, dx) + qmul(dy, dy) + qmul(dz, dz));
        b = clamp32(2 * (qmul(dx, ox) + qmul(dy, oy) + qmul(dz, oz)));
        c = clamp32(qmul(ox, ox) + qmul(oy, oy) + qmul(oz, oz) - qmul(sph_r, sph_r));
        disc = clamp32(qmul(b, b) - 4 * qmul(a, c));
        res = '0;
        if (disc < 0 || a == 0) return res;
        s = int_sqrt(64'(disc) << FRAC_BITS);
        num = -b - $signed(s);
        mag = 64'(num < 0 ? -num : num) << FRAC_BITS;
        den = 64'(a) * 2;
        q = mag / den;
        res.hit = 1'b1;
        if (num >= 0) begin
            if (q > 64'd2147483647) begin
                res.distance = Q_MAX; res.saturated = 1'b1;
            end else res.distance = q[31:0];
        end else begin
            if (q > 64'd2147483648) begin
                res.distance = Q_MIN; res.saturated = 1'b1;
            end else res.distance = -$signed(q[31:0]);
        end
        return res;
    endfunction

    // valid drops only for an idle burst, so back to back rays keep it high
    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    task automatic send_ray(input t_ray r);
        idle_gap();
        i_in_ray   <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        hit_queue.push_back(predict_hit(r));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CENTER_X: sph_cx = $signed(val);
            CFG_CENTER_Y: sph_cy = $signed(val);
            CFG_CENTER_Z: sph_cz = $signed(val);
            CFG_RADIUS:   sph_r = {33'd0, val[30:0]};
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_sphere(input logic [31:0] x, y, z, rad);
        drain();
        write_reg(CFG_CENTER_X, x);
        write_reg(CFG_CENTER_Y, y);
        write_reg(CFG_CENTER_Z, z);
        write_reg(CFG_RADIUS, rad);
    endtask

    function automatic logic [31:0] rnd_q(input int span);
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = 32'($signed($urandom_range(0, 2 * span)) - span) << 16;
            2: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: v = 32'($signed($urandom_range(0, 2 * span * 256)) - span * 256) << 8;
        endcase
        return v;
    endfunction

    function automatic t_ray rnd_ray(input bit aimed);
        t_ray r;
        r.origin_x = rnd_q(20); r.origin_y = rnd_q(20); r.origin_z = rnd_q(20);
        r.dir_x = rnd_q(4); r.dir_y = rnd_q(4); r.dir_z = rnd_q(4);
        if (aimed) begin
            // ray from a point short of the center in z toward the sphere, small random offsets
            r.origin_x = sph_cx[31:0] + 32'($signed($urandom_range(0, 65536)) - 32768);
            r.origin_y = sph_cy[31:0] + 32'($signed($urandom_range(0, 65536)) - 32768);
            r.origin_z = sph_cz[31:0] - 32'($urandom_range(1, 40) << 16);
            r.dir_x = 32'($signed($urandom_range(0, 8192)) - 4096);
            r.dir_y = 32'($signed($urandom_range(0, 8192)) - 4096);
            r.dir_z = 32'($urandom_range(1, 4) << 16);
        end
        return r;
    endfunction

    task automatic test_directed();
        t_ray r;
        r = '0; send_ray(r);                                   // zero direction
        r.dir_z = 32'h10000; send_ray(r);                      // straight hit
        r.dir_z = -32'sh10000; send_ray(r);                    // sphere behind
        r = '0; r.origin_x = 32'h10000; r.dir_z = 32'h10000; send_ray(r); // tangent
        r.origin_x = 32'h20000; send_ray(r);                   // miss
        r = '0; r.dir_x = 32'h1; send_ray(r);                  // direction floors to zero
        r = '0; r.dir_z = 32'h100; send_ray(r);                // tiny a, large t
        r = '0; r.dir_z = -32'sh100; r.origin_z = 32'h140000; send_ray(r);
        r = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff}; send_ray(r);
        r = '{32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000}; send_ray(r);
        r = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000, 32'h1};
        send_ray(r);
        r = '{32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 32'hffffffff}; send_ray(r);
    endtask

    task automatic test_random(input int n);
        repeat (n) send_ray(rnd_ray($urandom_range(0, 9) < 6));
    endtask

    task automatic test_sphere_extremes();
        set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        test_random(60);
        set_sphere(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
        test_random(60);
        drain();
        write_reg(8'd7, 32'hdeadbeef);     // unmapped index is dropped
        write_reg(8'hff, 32'h12345678);
        test_random(30);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (hit_queue.size() == 0) begin
                $error("unexpected result transaction");
                err_cnt++;
            end else begin
                want = hit_queue.pop_front();
                if (o_out_res.hit !== want.hit) begin
                    $error("hit exp %0d got %0d", want.hit, o_out_res.hit); err_cnt++;
                end
                if (o_out_res.distance !== want.distance) begin
                    $error("distance exp %0d got %0d", want.distance, o_out_res.distance);
                    err_cnt++;
                end
                if (o_out_res.saturated !== want.saturated) begin
                    $error("saturated exp %0d got %0d", want.saturated, o_out_res.saturated);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 15);
                i_out_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        err_cnt = 0; idle_on = 1;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_in_ray = '0;
        sph_cx = 0; sph_cy = 0; sph_cz = 64'(CENTER_Z_RST); sph_r = 64'(RADIUS_RST);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(400);
        set_sphere(32'h30000, -32'sh20000, 32'h50000, 32'h28000);
        test_random(400);
        test_sphere_extremes();
        set_sphere(32'h0, 32'h0, 32'ha0000, 32'h10000);
        test_random(300);
        idle_on = 0;
        test_random(300);
        drain();
        if (err_cnt == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
